// ----- sv/edfs_pkg.sv -----
// Shared types and constants of the EDF job scheduler.
// No dependencies; used by edfs_cell and edf_job_scheduler.
`default_nettype none
package edfs_pkg;

  localparam int unsigned DefMaxTasks  = 8;
  localparam int unsigned DefQueueDepth = 16;
  localparam int unsigned MaxReport    = 8;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Operation broadcast to every queue cell at once.
  typedef struct packed {
    logic ins;   // insert new job in deadline order
    logic pop;   // drop the head, all entries move one cell toward the head
    logic dec;   // head runs one unit
  } edfs_op_t;

endpackage
`default_nettype wire

// ----- sv/edfs_cell.sv -----
// One cell of the sorted job queue: valid, slot, absolute deadline, remaining time.
// Depends on edfs_pkg.
`default_nettype none
module edfs_cell #(
  parameter int unsigned SW = 3
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  edfs_pkg::edfs_op_t  op_i,
  input  wire                 dec_en_i,    // only the head cell decrements
  input  wire [SW-1:0]        new_slot_i,
  input  wire [31:0]          new_dl_i,
  input  wire [15:0]          new_rem_i,
  input  wire                 gb_left_i,   // new job sorts before the left neighbor
  input  wire                 left_v_i,
  input  wire [SW-1:0]        left_slot_i,
  input  wire [31:0]          left_dl_i,
  input  wire [15:0]          left_rem_i,
  input  wire                 right_v_i,
  input  wire [SW-1:0]        right_slot_i,
  input  wire [31:0]          right_dl_i,
  input  wire [15:0]          right_rem_i,
  output logic                gb_o,
  output logic                v_o,
  output logic [SW-1:0]       slot_o,
  output logic [31:0]         dl_o,
  output logic [15:0]         rem_o
);
  import edfs_pkg::*;

  logic          v_q, v_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [31:0]   dl_q, dl_d;
  logic [15:0]   rem_q, rem_d;

  // Ties: lower slot first, then older job, so equal keys stay ahead.
  assign gb_o = !v_q || (new_dl_i < dl_q) || ((new_dl_i == dl_q) && (new_slot_i < slot_q));

  always_comb begin
    v_d = v_q; slot_d = slot_q; dl_d = dl_q; rem_d = rem_q;
    if (op_i.pop) begin
      v_d = right_v_i; slot_d = right_slot_i; dl_d = right_dl_i; rem_d = right_rem_i;
    end else if (op_i.ins) begin
      if (gb_left_i) begin
        v_d = left_v_i; slot_d = left_slot_i; dl_d = left_dl_i; rem_d = left_rem_i;
      end else if (gb_o) begin
        v_d = 1'b1; slot_d = new_slot_i; dl_d = new_dl_i; rem_d = new_rem_i;
      end
    end else if (op_i.dec && dec_en_i) begin
      rem_d = rem_q - 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    dl_q   <= dl_d;
    rem_q  <= rem_d;
  end

  assign v_o    = v_q;
  assign slot_o = slot_q;
  assign dl_o   = dl_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ----- sv/edf_job_scheduler.sv -----
// Top level of the EDF job scheduler: task table, tick sequencer, release divider,
// per-slot counters and the chain of queue cells. Depends on edfs_pkg, edfs_cell.
//
// channel  dir  handshake               payload
// s_axis   in   s_axis_tvalid/tready    tuser=command, tdata=slot,period,deadline,exec
// m_axis   out  m_axis_tvalid/tready    tuser=result_kind, tlast=last, tdata=outcome
// cfg      in   cfg_we_i                cfg_wdata_i = tasks_in_use
//
// Sequence: a load is written into the table as it is accepted. A tick walks the slots in use,
// runs the remainder check for each slot whose period needs it (bit-serial divider, one
// bit a cycle), drops expired jobs one by one, runs the head job and sends the output beat.
// A finish pops every queued job, counting it as killed, then sends the report beats.
// Reset clears queue valids, table, counters; tasks_in_use resets to 1.
// s_axis_tready is high only while idle; a stalled m_axis beat holds everything.
`default_nettype none
module edf_job_scheduler #(
  parameter int unsigned MAX_TASKS   = edfs_pkg::DefMaxTasks,
  parameter int unsigned QUEUE_DEPTH = edfs_pkg::DefQueueDepth
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] task_slot, [18:3] period, [34:19] relative_deadline, [50:35] exec_time
  input  wire  [55:0] s_axis_tdata,
  // [1:0] command
  input  wire  [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [2:0] running_slot, [3] idle, [4] job_finished, [9:5] lost_this_tick,
  // [10] queue_overflow, [42:11] tick_number, [58:43] lost_total,
  // [74:59] complete_total, [90:75] killed_total, [95:91] zero
  output logic [95:0] m_axis_tdata,
  // [0] result_kind
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  wire         cfg_we_i,
  input  wire  [3:0]  cfg_wdata_i
);
  import edfs_pkg::*;

  localparam int unsigned SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_REL, ST_DIV, ST_DROP, ST_RUN, ST_KILL, ST_REP, ST_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [3:0] tiu_q;
  logic [3:0] n_act, n_rep;
  always_comb begin
    n_act = (tiu_q == 4'd0) ? 4'd1 : tiu_q;
    if (32'(n_act) > MAX_TASKS) n_act = 4'(MAX_TASKS);
    n_rep = (32'(n_act) > MaxReport) ? 4'(MaxReport) : n_act;
  end

  // input fields
  logic [2:0]  in_slot;
  logic [15:0] in_period, in_dl, in_exec;
  assign in_slot   = s_axis_tdata[2:0];
  assign in_period = s_axis_tdata[18:3];
  assign in_dl     = s_axis_tdata[34:19];
  assign in_exec   = s_axis_tdata[50:35];

  logic in_acc;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // task table, per-slot counters
  logic [15:0] tbl_p_q [MAX_TASKS];
  logic [15:0] tbl_d_q [MAX_TASKS];
  logic [15:0] tbl_e_q [MAX_TASKS];
  logic [15:0] lost_q  [MAX_TASKS];
  logic [15:0] cmpl_q  [MAX_TASKS];
  logic [15:0] kill_q  [MAX_TASKS];

  logic [31:0] tick_q;
  logic [3:0]  s_q;          // release walk / report index
  logic [4:0]  div_cnt_q;
  logic [15:0] div_r_q;
  logic [4:0]  lost_tick_q;
  logic        ovf_q;

  logic [SW-1:0] s_idx;
  assign s_idx = SW'(s_q);

  // queue chain
  logic            v   [QUEUE_DEPTH+1];
  logic [SW-1:0]   sl  [QUEUE_DEPTH+1];
  logic [31:0]     dlv [QUEUE_DEPTH+1];
  logic [15:0]     rmv [QUEUE_DEPTH+1];
  logic            gb  [QUEUE_DEPTH];
  edfs_op_t        op;

  logic [31:0] new_dl;
  logic [32:0] dl_sum;
  assign dl_sum = {1'b0, tick_q} + {17'd0, tbl_d_q[s_idx]};
  assign new_dl = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];

  assign v[QUEUE_DEPTH]   = 1'b0;
  assign sl[QUEUE_DEPTH]  = '0;
  assign dlv[QUEUE_DEPTH] = '0;
  assign rmv[QUEUE_DEPTH] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    edfs_cell #(.SW(SW)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .dec_en_i    (i == 0),
      .new_slot_i  (s_idx),
      .new_dl_i    (new_dl),
      .new_rem_i   (tbl_e_q[s_idx]),
      .gb_left_i   ((i == 0) ? 1'b0 : gb[(i == 0) ? 0 : i-1]),
      .left_v_i    ((i == 0) ? 1'b0 : v[(i == 0) ? 0 : i-1]),
      .left_slot_i (sl[(i == 0) ? 0 : i-1]),
      .left_dl_i   (dlv[(i == 0) ? 0 : i-1]),
      .left_rem_i  (rmv[(i == 0) ? 0 : i-1]),
      .right_v_i   (v[i+1]),
      .right_slot_i(sl[i+1]),
      .right_dl_i  (dlv[i+1]),
      .right_rem_i (rmv[i+1]),
      .gb_o        (gb[i]),
      .v_o         (v[i]),
      .slot_o      (sl[i]),
      .dl_o        (dlv[i]),
      .rem_o       (rmv[i])
    );
  end

  logic full, head_v;
  logic [SW-1:0] head_slot;
  assign full      = v[QUEUE_DEPTH-1];
  assign head_v    = v[0];
  assign head_slot = sl[0];

  // bit-serial remainder: tick_q mod period, MSB first
  logic [16:0] div_t;
  logic [16:0] div_n;
  assign div_t = {div_r_q, tick_q[5'd31 - div_cnt_q]};
  assign div_n = (div_t >= {1'b0, tbl_p_q[s_idx]}) ? div_t - {1'b0, tbl_p_q[s_idx]} : div_t;

  logic s_in_range;
  assign s_in_range = (s_q < n_act);

  logic rel_fire;
  assign rel_fire = ((state_q == ST_REL) && s_in_range && (tick_q == 32'd0)) ||
                    ((state_q == ST_DIV) && (div_cnt_q == 5'd31) && (div_n == 17'd0));

  logic drop_now, run_done;
  assign drop_now = (state_q == ST_DROP) && head_v && (dlv[0] <= tick_q);
  assign run_done = (state_q == ST_RUN) && head_v && (rmv[0] <= 16'd1);

  always_comb begin
    op.ins = rel_fire && !full;
    op.pop = drop_now || run_done || ((state_q == ST_KILL) && head_v);
    op.dec = (state_q == ST_RUN) && head_v && !run_done;
  end

  logic out_acc, rep_mode_q;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      tiu_q         <= 4'd1;
      tick_q        <= '0;
      s_q           <= '0;
      div_cnt_q     <= '0;
      div_r_q       <= '0;
      lost_tick_q   <= '0;
      ovf_q         <= 1'b0;
      rep_mode_q    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tuser  <= KIND_TICK;
      m_axis_tlast  <= 1'b0;
      for (int j = 0; j < MAX_TASKS; j++) begin
        tbl_p_q[j] <= '0; tbl_d_q[j] <= '0; tbl_e_q[j] <= '0;
        lost_q[j]  <= '0; cmpl_q[j]  <= '0; kill_q[j]  <= '0;
      end
    end else begin
      if (cfg_we_i) tiu_q <= cfg_wdata_i;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (s_axis_tuser)
              CMD_LOAD: begin
                if (32'(in_slot) < MAX_TASKS) begin
                  tbl_p_q[SW'(in_slot)] <= in_period;
                  tbl_d_q[SW'(in_slot)] <= in_dl;
                  tbl_e_q[SW'(in_slot)] <= in_exec;
                end
              end
              CMD_TICK: begin
                s_q <= '0; lost_tick_q <= '0; ovf_q <= 1'b0;
                state_q <= ST_REL;
              end
              CMD_FINISH: begin
                for (int j = 0; j < MAX_TASKS; j++) kill_q[j] <= '0;
                state_q <= ST_KILL;
              end
              default: ;
            endcase
          end
        end
        ST_REL: begin
          if (!s_in_range) begin
            state_q <= ST_DROP;
          end else if (tick_q == 32'd0 || tbl_p_q[s_idx] == 16'd0) begin
            s_q <= s_q + 4'd1;
          end else begin
            div_cnt_q <= '0; div_r_q <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_r_q   <= div_n[15:0];
          div_cnt_q <= div_cnt_q + 5'd1;
          if (div_cnt_q == 5'd31) begin
            s_q <= s_q + 4'd1;
            state_q <= ST_REL;
          end
        end
        ST_DROP: begin
          if (drop_now) begin
            if (lost_q[head_slot] != 16'hFFFF) lost_q[head_slot] <= lost_q[head_slot] + 16'd1;
            if (lost_tick_q != 5'd31) lost_tick_q <= lost_tick_q + 5'd1;
          end else begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (run_done && cmpl_q[head_slot] != 16'hFFFF)
            cmpl_q[head_slot] <= cmpl_q[head_slot] + 16'd1;
          // totals are zero in a tick outcome
          m_axis_tdata  <= {5'd0, 16'd0, 16'd0, 16'd0, tick_q, ovf_q, lost_tick_q,
                            run_done, !head_v, head_v ? 3'(head_slot) : 3'd0};
          m_axis_tuser  <= KIND_TICK;
          m_axis_tlast  <= 1'b1;
          m_axis_tvalid <= 1'b1;
          rep_mode_q    <= 1'b0;
          tick_q        <= tick_q + 32'd1;
          state_q       <= ST_OUT;
        end
        ST_KILL: begin
          if (head_v) begin
            if (kill_q[head_slot] != 16'hFFFF) kill_q[head_slot] <= kill_q[head_slot] + 16'd1;
          end else begin
            s_q <= '0;
            state_q <= ST_REP;
          end
        end
        ST_REP: begin
          // idle, finished, lost and overflow bits are zero in a report line
          m_axis_tdata  <= {5'd0, kill_q[s_idx], cmpl_q[s_idx], lost_q[s_idx], tick_q,
                            8'd0, 3'(s_q)};
          m_axis_tuser  <= KIND_REPORT;
          m_axis_tlast  <= (s_q + 4'd1 == n_rep);
          m_axis_tvalid <= 1'b1;
          rep_mode_q    <= 1'b1;
          s_q           <= s_q + 4'd1;
          state_q       <= ST_OUT;
        end
        ST_OUT: begin
          if (out_acc) begin
            m_axis_tvalid <= 1'b0;
            if (rep_mode_q && !m_axis_tlast) begin
              state_q <= ST_REP;
            end else begin
              if (rep_mode_q) begin
                tick_q <= '0;
                for (int j = 0; j < MAX_TASKS; j++) begin
                  lost_q[j] <= '0; cmpl_q[j] <= '0;
                end
              end
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (rel_fire && full) ovf_q <= 1'b1;
    end
  end

  // checks
  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.ins |-> !full) else $error("insert into full queue");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.pop |-> head_v) else $error("pop of empty queue");
  a_ready_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("input taken while beat pending");
  a_kill_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REP) |-> !head_v) else $error("report with jobs still queued");

endmodule
`default_nettype wire

// ----- tb/sv/edf_job_scheduler_tb.sv -----
// Self-checking testbench for edf_job_scheduler: directed table, then random runs.
// Depends on edfs_pkg and the RTL of the scheduler; carries its own EDF predictor.
`timescale 1ns / 100ps
module edf_job_scheduler_tb;
  import edfs_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int unsigned NSLOT = 8;
  localparam int unsigned QDEPTH = 16;
  localparam int unsigned SETTLE = 500;  // worst tick: 8 slots with divider, drops, run

  typedef struct packed {
    logic        kind;
    logic [2:0]  slot;
    logic        idle;
    logic        fin;
    logic [4:0]  lost;
    logic        ovf;
    logic [31:0] tick;
    logic [15:0] lost_tot;
    logic [15:0] done_tot;
    logic [15:0] kill_tot;
    logic        last;
  } outcome_t;

  typedef struct {
    bit          is_cfg;
    logic [3:0]  cfg;
    logic [1:0]  cmd;
    logic [2:0]  slot;
    logic [15:0] per;
    logic [15:0] dl;
    logic [15:0] ex;
    bit          has_exp;
    outcome_t    exp;
  } stim_t;

  typedef struct {
    logic [2:0]  slot;
    logic [31:0] deadline;
    logic [15:0] remaining;
  } job_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [55:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;
  wire         s_ready;
  wire         m_valid;
  wire  [95:0] m_data;
  wire         m_user;
  wire         m_last;

  always #5 clk = ~clk;

  edf_job_scheduler dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user),
    .m_axis_tlast (m_last),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  // Predictor state: mirror of the task table, deadline-ordered job queue, counters.
  logic [3:0]  slots_cfg = 4'd1;
  logic [15:0] tbl_per [NSLOT];
  logic [15:0] tbl_dl  [NSLOT];
  logic [15:0] tbl_ex  [NSLOT];
  job_t        ready_jobs[$];
  logic [31:0] sched_tick;
  logic [15:0] lost_cnt [NSLOT];
  logic [15:0] done_cnt [NSLOT];

  outcome_t    pending_beats[$];
  stim_t       stim[$];
  int          mismatches = 0;
  bit          calm = 1'b0;      // no idling on either side
  bit          squeeze = 1'b0;   // ask the receiver for its long hold-off

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic int unsigned active_slots();
    if (slots_cfg == 0) return 1;
    if (slots_cfg > NSLOT) return NSLOT;
    return slots_cfg;
  endfunction

  function automatic void clear_run();
    ready_jobs.delete();
    sched_tick = '0;
    for (int i = 0; i < NSLOT; i++) begin
      lost_cnt[i] = '0;
      done_cnt[i] = '0;
    end
  endfunction

  // Insert in deadline order; ties to the lower slot, then to the older job.
  function automatic bit enqueue_job(job_t j);
    int pos;
    if (ready_jobs.size() >= QDEPTH) return 1'b0;
    pos = 0;
    while (pos < ready_jobs.size()) begin
      if (j.deadline < ready_jobs[pos].deadline) break;
      if (j.deadline == ready_jobs[pos].deadline && j.slot < ready_jobs[pos].slot) break;
      pos++;
    end
    ready_jobs.insert(pos, j);
    return 1'b1;
  endfunction

  function automatic void predict_tick();
    outcome_t o;
    job_t     j;
    job_t     kept[$];
    logic [32:0] abs_dl;
    logic [31:0] now;
    int unsigned dropped;
    now = sched_tick;
    o = '0;
    for (int s = 0; s < active_slots(); s++) begin
      if (now == 0 || (tbl_per[s] != 0 && now % tbl_per[s] == 0)) begin
        abs_dl = {1'b0, now} + tbl_dl[s];
        j.slot = s[2:0];
        j.deadline = abs_dl[32] ? 32'hFFFF_FFFF : abs_dl[31:0];
        j.remaining = tbl_ex[s];
        if (!enqueue_job(j)) o.ovf = 1'b1;
      end
    end
    dropped = 0;
    foreach (ready_jobs[i]) begin
      if (now >= ready_jobs[i].deadline) begin
        lost_cnt[ready_jobs[i].slot] = sat_inc(lost_cnt[ready_jobs[i].slot]);
        if (dropped < 31) dropped++;
      end else begin
        kept.push_back(ready_jobs[i]);
      end
    end
    ready_jobs = kept;
    o.kind = KIND_TICK;
    o.lost = dropped[4:0];
    o.tick = now;
    o.last = 1'b1;
    if (ready_jobs.size() == 0) begin
      o.idle = 1'b1;
    end else begin
      o.slot = ready_jobs[0].slot;
      if (ready_jobs[0].remaining <= 1) begin
        done_cnt[ready_jobs[0].slot] = sat_inc(done_cnt[ready_jobs[0].slot]);
        ready_jobs.delete(0);
        o.fin = 1'b1;
      end else begin
        ready_jobs[0].remaining--;
      end
    end
    pending_beats.push_back(o);
    sched_tick = now + 32'd1;
  endfunction

  function automatic void predict_finish();
    logic [15:0] killed [NSLOT];
    outcome_t o;
    int unsigned n;
    for (int i = 0; i < NSLOT; i++) killed[i] = '0;
    foreach (ready_jobs[i]) killed[ready_jobs[i].slot] = sat_inc(killed[ready_jobs[i].slot]);
    n = active_slots();
    for (int k = 0; k < n; k++) begin
      o = '0;
      o.kind = KIND_REPORT;
      o.slot = k[2:0];
      o.tick = sched_tick;
      o.lost_tot = lost_cnt[k];
      o.done_tot = done_cnt[k];
      o.kill_tot = killed[k];
      o.last = (k + 1 == n);
      pending_beats.push_back(o);
    end
    clear_run();
  endfunction

  function automatic void predict_beat(stim_t it);
    case (it.cmd)
      CMD_LOAD: begin
        tbl_per[it.slot] = it.per;
        tbl_dl[it.slot] = it.dl;
        tbl_ex[it.slot] = it.ex;
      end
      CMD_TICK:   predict_tick();
      CMD_FINISH: predict_finish();
      default: ;  // unknown command: no effect
    endcase
  endfunction

  function automatic stim_t job_cmd(logic [1:0] cmd, logic [2:0] slot, logic [15:0] per,
                                    logic [15:0] dl, logic [15:0] ex);
    stim_t it;
    it = '{default: '0};
    it.cmd = cmd;
    it.slot = slot;
    it.per = per;
    it.dl = dl;
    it.ex = ex;
    return it;
  endfunction

  function automatic stim_t cfg_cmd(logic [3:0] v);
    stim_t it;
    it = '{default: '0};
    it.is_cfg = 1'b1;
    it.cfg = v;
    return it;
  endfunction

  function automatic stim_t with_exp(stim_t it, outcome_t o);
    it.has_exp = 1'b1;
    it.exp = o;
    return it;
  endfunction

  // Random field: mostly small so jobs finish and miss deadlines, sometimes any 16 bits.
  function automatic logic [15:0] rnd_field(int unsigned hi);
    if ($urandom_range(0, 9) == 0) return 16'($urandom());
    return 16'($urandom_range(0, hi));
  endfunction

  // Receiver: random back-pressure, one long hold-off so the block fills and stalls.
  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (squeeze && !held) begin
        held = 1'b1;
        m_ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      m_ready <= calm || ($urandom_range(0, 99) >= 37);
    end
  end

  // Output checker: compare each accepted beat with the oldest expectation.
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst_n && m_valid && m_ready) begin
      got = '0;
      got.kind = m_user;
      got.slot = m_data[2:0];
      got.idle = m_data[3];
      got.fin = m_data[4];
      got.lost = m_data[9:5];
      got.ovf = m_data[10];
      got.tick = m_data[42:11];
      got.lost_tot = m_data[58:43];
      got.done_tot = m_data[74:59];
      got.kill_tot = m_data[90:75];
      got.last = m_last;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %p", got);
      end else begin
        want = pending_beats.pop_front();
        if (got.kind !== want.kind || got.slot !== want.slot || got.idle !== want.idle ||
            got.fin !== want.fin || got.lost !== want.lost || got.ovf !== want.ovf ||
            got.tick !== want.tick || got.lost_tot !== want.lost_tot ||
            got.done_tot !== want.done_tot || got.kill_tot !== want.kill_tot ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("edf_job_scheduler_tb failed");
    $finish;
  end

  initial begin
    outcome_t o;
    stim_t    it;
    int       n_items;
    int       n_ticks;
    logic [3:0] cfg_pick [6];

    cfg_pick = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd9};
    for (int i = 0; i < NSLOT; i++) begin
      tbl_per[i] = '0;
      tbl_dl[i] = '0;
      tbl_ex[i] = '0;
    end
    clear_run();

    // Directed table. After reset slot 0 is all zero: it releases at tick 0
    // with deadline 0 and the job is lost the same tick.
    o = '0;
    o.kind = KIND_TICK; o.idle = 1'b1; o.lost = 5'd1; o.tick = 32'd0; o.last = 1'b1;
    stim.push_back(with_exp(job_cmd(CMD_TICK, 3'd0, '0, '0, '0), o));
    o = '0;
    o.kind = KIND_REPORT; o.tick = 32'd1; o.lost_tot = 16'd1; o.last = 1'b1;
    stim.push_back(with_exp(job_cmd(CMD_FINISH, 3'd0, '0, '0, '0), o));
    stim.push_back(job_cmd(CMD_UNKNOWN, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    stim.push_back(job_cmd(CMD_LOAD, 3'd0, 16'd1, 16'd3, 16'd2));
    stim.push_back(job_cmd(CMD_LOAD, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    stim.push_back(job_cmd(CMD_LOAD, 3'd1, 16'd0, 16'hFFFF, 16'd0));  // zero period and exec
    stim.push_back(job_cmd(CMD_LOAD, 3'd2, 16'd2, 16'd0, 16'd1));     // zero deadline
    stim.push_back(job_cmd(CMD_LOAD, 3'd3, 16'd1, 16'd1, 16'd1));
    stim.push_back(job_cmd(CMD_LOAD, 3'd4, 16'd1, 16'd40, 16'd30));
    stim.push_back(job_cmd(CMD_LOAD, 3'd5, 16'd1, 16'd40, 16'd30));
    stim.push_back(job_cmd(CMD_LOAD, 3'd6, 16'd3, 16'd2, 16'd5));
    stim.push_back(cfg_cmd(4'd8));
    // Several slots release every tick: the queue overflows.
    for (int i = 0; i < 5; i++) stim.push_back(job_cmd(CMD_TICK, '0, '0, '0, '0));
    stim.push_back(job_cmd(CMD_FINISH, '0, '0, '0, '0));
    stim.push_back(cfg_cmd(4'd15));  // above the slot count: treated as eight
    stim.push_back(job_cmd(CMD_TICK, '0, '0, '0, '0));
    stim.push_back(job_cmd(CMD_TICK, '0, '0, '0, '0));
    stim.push_back(job_cmd(CMD_FINISH, '0, '0, '0, '0));
    stim.push_back(cfg_cmd(4'd0));   // zero: treated as one
    stim.push_back(job_cmd(CMD_TICK, '0, '0, '0, '0));
    stim.push_back(job_cmd(CMD_FINISH, '0, '0, '0, '0));

    // Random runs: configure, load some slots, tick a while, usually finish.
    n_items = 0;
    for (int ph = 0; n_items < 330; ph++) begin
      stim.push_back(cfg_cmd(ph < 6 ? cfg_pick[ph] : 4'($urandom_range(0, 15))));
      repeat ($urandom_range(1, 8)) begin
        stim.push_back(job_cmd(CMD_LOAD, 3'($urandom_range(0, 7)), rnd_field(6),
                               rnd_field(9), rnd_field(4)));
        n_items++;
      end
      n_ticks = $urandom_range(4, 24);
      for (int t = 0; t < n_ticks; t++) begin
        case ($urandom_range(0, 19))
          0: stim.push_back(job_cmd(CMD_UNKNOWN, 3'($urandom()), 16'($urandom()),
                                    16'($urandom()), 16'($urandom())));
          1: stim.push_back(job_cmd(CMD_LOAD, 3'($urandom_range(0, 7)), rnd_field(6),
                                    rnd_field(9), rnd_field(4)));
          default: stim.push_back(job_cmd(CMD_TICK, 3'($urandom()), 16'($urandom()),
                                          16'($urandom()), 16'($urandom())));
        endcase
        n_items++;
      end
      if ($urandom_range(0, 4) != 0) begin
        stim.push_back(job_cmd(CMD_FINISH, 3'($urandom()), 16'($urandom()),
                               16'($urandom()), 16'($urandom())));
        n_items++;
      end
    end
    stim.push_back(job_cmd(CMD_FINISH, '0, '0, '0, '0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim[k]) begin
      it = stim[k];
      calm = (k >= stim.size() / 3) && (k < stim.size() / 3 + 60);
      if (k == stim.size() / 2) squeeze = 1'b1;
      if (it.is_cfg) begin
        // Register writes only with the block idle and all results drained.
        s_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= it.cfg;
        @(posedge clk);
        cfg_we <= 1'b0;
        slots_cfg = it.cfg;
      end else begin
        if (!calm && $urandom_range(0, 99) < 37) begin
          s_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user <= it.cmd;
        s_data <= {5'd0, it.ex, it.dl, it.per, it.slot};
        do @(posedge clk); while (!s_ready);
        predict_beat(it);
        if (it.has_exp) pending_beats[$] = it.exp;
      end
    end
    s_valid <= 1'b0;

    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("edf_job_scheduler_tb passed");
    end else begin
      $display("edf_job_scheduler_tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/edfs_pkg.sv
sv/edfs_cell.sv
sv/edf_job_scheduler.sv
tb/sv/edf_job_scheduler_tb.sv
